@@ hw/rtl/algr_pkg.sv @@
// ----------------------------------------------------------------------------
// algr_pkg
// Shared types and constants of the audio loopback with gain and headphone ramp.
// ----------------------------------------------------------------------------
package algr_pkg;

    // Sample and stream widths
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int RAMP_W      = 17;
    localparam int SPB_W       = 11;
    localparam int IN_TDATA_W  = 24;  // sample, block_start, headphone_connected
    localparam int IN_TUSER_W  = 1;   // command
    localparam int OUT_TDATA_W = 32;  // left_sample, right_sample

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Register indexes
    localparam cfg_idx_t REG_SAMPLES_PER_BLOCK = 2'd0;
    localparam cfg_idx_t REG_INPUT_GAIN        = 2'd1;
    localparam cfg_idx_t REG_OUTPUT_GAIN       = 2'd2;

    // Command codes
    localparam logic CMD_CAPTURE  = 1'b0;
    localparam logic CMD_PLAYBACK = 1'b1;

    // Ramp constants, Q1.16
    localparam logic [RAMP_W-1:0] RAMP_FULL = 17'd65536;
    localparam logic [RAMP_W-1:0] RAMP_STEP = 17'd262;

    // Reset values of the registers
    localparam logic [SPB_W-1:0]  SPB_RESET  = 11'd64;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

endpackage

@@ hw/rtl/audio_loopback_gain_ramp.sv @@
// ----------------------------------------------------------------------------
// audio_loopback_gain_ramp
// Mono-to-stereo loopback: circular sample store, gain and headphone ramp.
// ----------------------------------------------------------------------------
// Input stream (s_axis_*): tuser selects the command. A capture transaction
// writes tdata's sample into the store at the write pointer and gives no
// result. A playback transaction reads the store at the read pointer, on
// block_start steps the ramp (or zeroes it without headphone_connected),
// scales the sample by input gain, output gain and ramp, and gives one
// result on m_axis_*, with the same value on left and right.
// Throughput: a capture every cycle while idle; a playback item is not
// taken until the one before it leaves the saturate stage, since the store
// read and the two-stage multiply chain run one item at a time.
// The result sits in an output register, so the next item is taken while
// it waits; a stalled receiver holds only the saturate stage of the next
// playback item until the register frees.
// Reset: a clearing pass writes zeros through the whole store, one entry a
// cycle; s_axis_tready stays low meanwhile.
// Configuration writes (cfg_we) take effect at once; make them while no
// playback item is in flight. Writing samples_per_block returns both
// pointers to zero.
// ----------------------------------------------------------------------------
module audio_loopback_gain_ramp #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  algr_pkg::cfg_idx_t                cfg_index,
    input  algr_pkg::cfg_data_t               cfg_wdata,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [15:0] sample, [16] block_start, [17] headphone_connected, zeros
    input  logic [algr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: [0] command
    input  logic [algr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: [15:0] left_sample, [31:16] right_sample
    output logic [algr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import algr_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);

    // State codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [RAMP_W-1:0]   ramp_reg, ramp_next;
    logic [SPB_W-1:0]    spb_reg;
    logic [GAIN_W-1:0]   in_gain_reg;
    logic [GAIN_W-1:0]   out_gain_reg;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_data_reg;

    // Datapath registers
    logic                neg_reg;
    logic [31:0]         p1_reg;
    logic [GAIN_W-1:0]   g_reg;
    logic [47:0]         p2_reg;

    // Input fields
    logic                cmd;
    sample_t             in_sample;
    logic                in_block_start;
    logic                in_headphone;
    logic                in_accept;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Arithmetic
    logic [LW-1:0]       ring_len;
    logic [31:0]         spb_ext;
    logic [16:0]         mag;
    logic [32:0]         p1_full;
    logic [32:0]         g_full;
    logic [62:0]         m_full;
    logic [19:0]         q;
    logic [SAMPLE_W-1:0] res;
    logic [RAMP_W-1:0]   ramp_up;
    logic                out_free;

    assign cmd            = s_axis_tuser[0];
    assign in_sample      = sample_t'(s_axis_tdata[15:0]);
    assign in_block_start = s_axis_tdata[16];
    assign in_headphone   = s_axis_tdata[17];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Clamp the ring length to 1..STORE_DEPTH
    always_comb
    begin
        spb_ext = 32'(spb_reg);
        if (spb_ext == 32'd0)
        begin
            ring_len = LW'(1);
        end
        else if (spb_ext > 32'(STORE_DEPTH))
        begin
            ring_len = LW'(STORE_DEPTH);
        end
        else
        begin
            ring_len = LW'(spb_ext);
        end
    end

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] ptr,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] nxt;
        nxt = LW'(ptr) + LW'(1);
        if (nxt >= len)
        begin
            advance = '0;
        end
        else
        begin
            advance = AW'(nxt);
        end
    endfunction

    // Drive the store: clearing pass, capture write or playback read
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = in_accept && (cmd == CMD_CAPTURE);
            ram_addr  = (cmd == CMD_CAPTURE) ? wr_ptr_reg : rd_ptr_reg;
            ram_wdata = in_sample;
        end
    end

    algr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Ramp step, capped at full scale
    assign ramp_up = (ramp_reg + RAMP_STEP > RAMP_FULL) ? RAMP_FULL : ramp_reg + RAMP_STEP;

    // Control sequencing
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        ramp_next    = ramp_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_CAPTURE)
                    begin
                        wr_ptr_next = advance(wr_ptr_reg, ring_len);
                    end
                    else
                    begin
                        rd_ptr_next = advance(rd_ptr_reg, ring_len);
                        if (in_block_start)
                        begin
                            ramp_next = in_headphone ? ramp_up : '0;
                        end
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Writing the ring length returns both pointers to zero
        if (cfg_we && (cfg_index == REG_SAMPLES_PER_BLOCK))
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            ramp_reg     <= RAMP_FULL;
            m_valid_reg  <= 1'b0;
            spb_reg      <= SPB_RESET;
            in_gain_reg  <= GAIN_RESET;
            out_gain_reg <= GAIN_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            ramp_reg    <= ramp_next;
            m_valid_reg <= m_valid_next;
            // Register writes; unknown indexes drop
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLES_PER_BLOCK: spb_reg      <= cfg_wdata[SPB_W-1:0];
                    REG_INPUT_GAIN:        in_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_OUTPUT_GAIN:       out_gain_reg <= cfg_wdata[GAIN_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // Magnitude of the stored sample and the first products
    assign mag     = ram_rdata[15] ? (17'h10000 - {1'b0, ram_rdata}) : {1'b0, ram_rdata};
    assign p1_full = mag * in_gain_reg;
    assign g_full  = out_gain_reg * ramp_reg;

    // Times 32767 as shift and subtract, then keep bits 62..43
    assign m_full = {p2_reg, 15'b0} - {15'b0, p2_reg};
    assign q      = m_full[62:43];

    // Saturate toward int16
    always_comb
    begin
        if (neg_reg)
        begin
            res = (q > 20'd32768) ? 16'h8000 : 16'(17'h10000 - 17'(q));
        end
        else
        begin
            res = (q > 20'd32767) ? 16'h7FFF : q[15:0];
        end
    end

    // Multiply pipeline and output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            neg_reg <= ram_rdata[15];
            p1_reg  <= p1_full[31:0];
            g_reg   <= g_full[31:16];
        end
        if (state_reg == ST_MUL)
        begin
            p2_reg <= p1_reg * g_reg;
        end
        if ((state_reg == ST_SAT) && out_free)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_data_reg, m_data_reg};

`ifndef SYNTH
    // No transaction is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input taken during store clear");

    // A new result only comes out of the saturate stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_SAT))
        else $error("result without playback item");

    // The store is not written while a playback item is in flight
    a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READ) || (state_reg == ST_MUL) || (state_reg == ST_SAT))
        |-> !ram_we)
        else $error("store written during playback");

    // The ramp never exceeds full scale
    a_ramp_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_reg <= RAMP_FULL)
        else $error("ramp above full scale");
`endif

endmodule

@@ hw/rtl/algr_ram.sv @@
// ----------------------------------------------------------------------------
// algr_ram
// Generic single-port RAM with one write or read per cycle and registered read.
// ----------------------------------------------------------------------------
module algr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register the read data every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio loopback with gain and headphone ramp.
// A behavioral copy of the store, both pointers, the ramp and the registers
// runs beside the block. Every input transaction updates it, and every
// playback transaction queues the frame it should produce. Each output
// transaction is checked field by field against the oldest queued frame.
// Directed tests come first, then random phases. The input side sends in
// bursts and the output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;

    import algr_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int PTR_W        = $clog2(STORE_DEPTH);
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam cfg_idx_t REG_UNUSED = 2'd3;

    typedef struct packed {
        sample_t right;
        sample_t left;
    } frame_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    cfg_idx_t               cfg_index = '0;
    cfg_data_t              cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Loopback shadow state
    logic [15:0]        store_image [STORE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_model;
    logic [PTR_W-1:0]   rd_ptr_model;
    logic [RAMP_W-1:0]  ramp_model;
    logic [SPB_W-1:0]   ring_cfg;
    logic [GAIN_W-1:0]  in_gain_cfg;
    logic [GAIN_W-1:0]  out_gain_cfg;
    frame_t             expected_frames [$];
    int                 error_count = 0;

    // Sender and receiver pacing
    int   burst_left = 0;
    int   stall_request = 0;
    int   stall_left = 0;
    int   pace_left = 0;
    logic [31:0] pace_bits = '0;
    logic pace_free = 1'b0;
    int   quiet_cycles = 0;

    audio_loopback_gain_ramp #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance a ring position, wrapping at the ring length in use
    function automatic logic [PTR_W-1:0] next_ring_pos(logic [PTR_W-1:0] pos);
        int unsigned len;
        int unsigned nxt;
        len = (ring_cfg == 0) ? 1 : (ring_cfg > STORE_DEPTH) ? STORE_DEPTH : ring_cfg;
        nxt = pos + 1;
        return (nxt >= len) ? '0 : PTR_W'(nxt);
    endfunction

    // Apply one input transaction to the shadow state; queue a frame on playback
    function automatic void loopback_step(logic cmd, logic [15:0] smp, logic bs, logic hp);
        logic [15:0] raw;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] comb;
        logic [63:0] prod;
        logic [63:0] q;
        frame_t      fr;
        if (cmd == CMD_CAPTURE)
        begin
            store_image[wr_ptr_model] = smp;
            wr_ptr_model = next_ring_pos(wr_ptr_model);
            return;
        end
        raw = store_image[rd_ptr_model];
        rd_ptr_model = next_ring_pos(rd_ptr_model);
        // Step the ramp before scaling
        if (bs)
        begin
            if (hp)
                ramp_model = (ramp_model + RAMP_STEP > RAMP_FULL) ? RAMP_FULL
                                                                   : ramp_model + RAMP_STEP;
            else
                ramp_model = '0;
        end
        // Scale the magnitude, truncate, then saturate with the sign restored
        neg  = raw[15];
        mag  = neg ? (64'd65536 - 64'(raw)) : 64'(raw);
        comb = (64'(out_gain_cfg) * 64'(ramp_model)) >> 16;
        prod = mag * 64'(in_gain_cfg) * comb * 64'd32767;
        q    = prod >> 43;
        if (neg)
        begin
            if (q > 64'd32768)
                q = 64'd32768;
            fr.left = 16'(64'd65536 - q);
        end
        else
        begin
            if (q > 64'd32767)
                q = 64'd32767;
            fr.left = 16'(q);
        end
        fr.right = fr.left;
        expected_frames.push_back(fr);
    endfunction

    // Check output transactions, track register writes and input transactions
    always @(posedge clk)
    begin : scoreboard
        frame_t got;
        frame_t want;
        if (!rst_n)
        begin
            foreach (store_image[i])
                store_image[i] = '0;
            wr_ptr_model = '0;
            rd_ptr_model = '0;
            ramp_model   = RAMP_FULL;
            ring_cfg     = SPB_RESET;
            in_gain_cfg  = GAIN_RESET;
            out_gain_cfg = GAIN_RESET;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_frames.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected output: L=%0d R=%0d", got.left, got.right);
                    error_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left || got.right !== want.right)
                    begin
                        if (error_count < 10)
                            $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                     want.left, want.right, got.left, got.right);
                        error_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLES_PER_BLOCK:
                    begin
                        ring_cfg     = cfg_wdata[SPB_W-1:0];
                        wr_ptr_model = '0;
                        rd_ptr_model = '0;
                    end
                    REG_INPUT_GAIN:  in_gain_cfg  = cfg_wdata;
                    REG_OUTPUT_GAIN: out_gain_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                loopback_step(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[16],
                              s_axis_tdata[17]);
        end
    end

    // Receiver: long hold-off on request, otherwise a random ready pattern
    always @(posedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pace_left == 0)
            begin
                pace_bits = $urandom();
                pace_left = 32;
                pace_free = ($urandom_range(0, 3) == 0);
            end
            pace_left--;
            m_axis_tready <= pace_free | pace_bits[pace_left];
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until accepted; bursts with random gaps
    task automatic send_item(logic cmd, logic [15:0] smp, logic bs, logic hp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - 18){1'b0}}, hp, bs, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid, wait for every queued frame, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Hold one register write for one cycle; the caller drops the enable
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Write all registers; the unused index gets noise, ring length gets junk upper bits
    task automatic apply_settings(logic [SPB_W-1:0] spb, logic [GAIN_W-1:0] gin,
                                  logic [GAIN_W-1:0] gout);
        write_reg(REG_UNUSED, cfg_data_t'($urandom()));
        write_reg(REG_SAMPLES_PER_BLOCK, {(CFG_DATA_W - SPB_W)'($urandom()), spb});
        write_reg(REG_INPUT_GAIN, gin);
        write_reg(REG_OUTPUT_GAIN, gout);
        cfg_we <= 1'b0;
    endtask

    // Sample extremes through the store at reset settings
    task automatic test_capture_extremes();
        send_item(CMD_CAPTURE, 16'h7FFF, 1'b0, 1'b1);
        send_item(CMD_CAPTURE, 16'h8000, 1'b1, 1'b0);
        send_item(CMD_CAPTURE, 16'hFFFF, 1'b0, 1'b0);
        send_item(CMD_CAPTURE, 16'h0001, 1'b1, 1'b1);
        send_item(CMD_CAPTURE, 16'h0000, 1'b0, 1'b1);
        repeat (5)
            send_item(CMD_PLAYBACK, 16'($urandom()), 1'b0, 1'b1);
        wait_idle();
    endtask

    // Full-scale gains saturate, zero gains mute; zero and oversize ring lengths
    task automatic test_gain_extremes();
        apply_settings(11'd0, 16'hFFFF, 16'hFFFF);
        send_item(CMD_CAPTURE, 16'h8000, 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b0, 1'b1);
        send_item(CMD_CAPTURE, 16'h7FFF, 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'hFFFF, 1'b0, 1'b1);
        send_item(CMD_CAPTURE, 16'h0001, 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b0, 1'b1);
        wait_idle();
        apply_settings(11'd2047, 16'h0000, 16'h0000);
        send_item(CMD_CAPTURE, 16'h7FFF, 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Ramp at the cap, headphone flag without block start, mute and recovery
    task automatic test_ramp_and_headphones();
        apply_settings(11'd16, GAIN_RESET, GAIN_RESET);
        repeat (5)
            send_item(CMD_CAPTURE, 16'($urandom()), 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b1, 1'b1);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b0, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b1, 1'b0);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b0, 1'b1);
        send_item(CMD_PLAYBACK, 16'h0000, 1'b1, 1'b1);
        wait_idle();
    endtask

    // Hold the output off long enough that the input side backs up
    task automatic test_backpressure();
        stall_request = 400;
        for (int i = 0; i < 24; i++)
            send_item((i % 2 == 1) ? CMD_PLAYBACK : CMD_CAPTURE, 16'($urandom()),
                      (i % 8 == 1), 1'b1);
        wait_idle();
    endtask

    // Capture a block, play it back with block start on its first frame; some noise
    task automatic run_phase(int n_items, int max_blk, int mute_pct, int noise_pct);
        int sent;
        int n;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_item(1'($urandom()), 16'($urandom()), 1'($urandom()), 1'($urandom()));
                sent++;
            end
            else
            begin
                n = $urandom_range(1, max_blk);
                for (int i = 0; i < n; i++)
                    send_item(CMD_CAPTURE, 16'($urandom()), 1'($urandom()), 1'($urandom()));
                for (int i = 0; i < n; i++)
                    send_item(CMD_PLAYBACK, 16'($urandom()), (i == 0),
                              (i == 0) ? ($urandom_range(0, 99) >= mute_pct)
                                       : 1'($urandom()));
                sent += 2 * n;
            end
        end
        wait_idle();
    endtask

    // Random phases over several settings; the first climbs the ramp to its cap
    task automatic test_random_phases();
        apply_settings(11'($urandom_range(1, 8)), GAIN_RESET, 16'd20000);
        run_phase(600, 1, 0, 0);
        apply_settings(11'd1024, 16'($urandom()), 16'($urandom()));
        run_phase(300, 16, 5, 10);
        apply_settings(11'd2047, 16'hFFFF, 16'hFFFF);
        run_phase(300, 40, 10, 20);
        apply_settings(11'd1, 16'($urandom()), 16'($urandom()));
        run_phase(300, 8, 20, 30);
        apply_settings(11'($urandom()), 16'($urandom()), GAIN_RESET);
        run_phase(300, 64, 5, 10);
    endtask

    initial
    begin : run_tests
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_capture_extremes();
        test_gain_extremes();
        test_ramp_and_headphones();
        test_backpressure();
        test_random_phases();
        if (error_count == 0 && expected_frames.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/algr_pkg.sv
hw/rtl/algr_ram.sv
hw/rtl/audio_loopback_gain_ramp.sv
sim/tb_top.sv
